// File: design/line_segment_closest_point_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the closest point block
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_CLOSEST_POINT_ASSERT_SVH
`define LINE_SEGMENT_CLOSEST_POINT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSCP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lscp assertion failed");
`define LSCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lscp assertion failed");
`else
`define LSCP_ASSERT(lbl, clk, rstn, prop)
`define LSCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/lscp_pkg.sv
// ----------------------------------------------------------------------------
// lscp_pkg
// Widths, types and helpers shared by the closest point block.
// ----------------------------------------------------------------------------
`default_nettype none
package lscp_pkg;

  localparam int LAM_FB     = 30;              // fraction bits of lambda
  localparam int CW         = 32;              // coordinate width
  localparam int DW         = CW + 1;          // coordinate difference width
  localparam int CUT_W      = 31;              // cutoff register width
  localparam int MAG_W      = 2 * DW - 1;      // |dot| and |L|^2
  localparam int SQ_STEPS   = 35;              // root bits tried
  localparam int ROOT_W     = SQ_STEPS;
  localparam int SQ_W       = 2 * SQ_STEPS;
  localparam int LAM_W      = LAM_FB + 2;      // saturated lambda
  localparam int QW         = LAM_W + 1;       // quotient bits incl. overflow
  localparam int LD_W       = MAG_W + QW;      // lambda divider width
  localparam int CD_W       = ROOT_W + QW;     // cutoff divider width
  localparam int LE_W       = QW + 2;
  localparam int PO_W       = LAM_W + DW;
  localparam int PC_W       = LAM_W + 1 + DW;
  localparam int ACC_W      = PC_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic signed [LAM_W-1:0] LAM_MAX = {1'b0, {(LAM_W-1){1'b1}}};
  localparam logic signed [LAM_W-1:0] LAM_MIN = {1'b1, {(LAM_W-1){1'b0}}};
  localparam logic signed [LE_W-1:0]  LE_ONE  = LE_W'(1) << LAM_FB;
  localparam logic signed [LE_W-1:0]  LE_MIN  = LE_W'(LAM_MIN);
  localparam logic signed [ACC_W-1:0] ACC_OUT_MAX = (ACC_W'(1) << (CW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_OUT_MIN = -ACC_OUT_MAX - ACC_W'(1);

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, ex, ey, px, py;
    logic signed [CW-1:0] v1x, v1y, v2x, v2y;
    logic                 pos_ok, vel_ok;
  } raw_t;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy;
    logic signed [DW-1:0] obx, oby;   // start minus point
    logic signed [DW-1:0] lx, ly;
    logic signed [CW-1:0] v1x, v1y;
    logic signed [DW-1:0] vdx, vdy;
    logic                 pos_ok, vel_ok;
    logic                 dot_neg;
    logic [MAG_W-1:0]     dot_mag;
    logic [MAG_W-1:0]     len2;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] offset_x, offset_y, vel_x, vel_y;
    logic                 offset_valid, vel_valid;
    logic signed [CW-1:0] center_x, center_y;
    logic                 center_valid;
  } res_t;

  // (base << sh + prod) >> sh, floor, saturated to the coordinate range
  function automatic logic signed [CW-1:0] lerp_sat(input logic signed [ACC_W-1:0] base,
                                                   input logic signed [ACC_W-1:0] prod,
                                                   input int unsigned sh);
    logic signed [ACC_W-1:0] acc;
    acc = ((base <<< sh) + prod) >>> sh;
    if (acc > ACC_OUT_MAX) return ACC_OUT_MAX[CW-1:0];
    if (acc < ACC_OUT_MIN) return ACC_OUT_MIN[CW-1:0];
    return acc[CW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/lscp_front.sv
// ----------------------------------------------------------------------------
// lscp_front
// Takes a word, forms differences, squares and dot products.
// ----------------------------------------------------------------------------
`default_nettype none
module lscp_front import lscp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire raw_t  raw_i,
  input  wire logic  adv_i,
  output logic       push_o,
  output item_t      item_o
);

  logic s1_v_q, s2_v_q;
  logic signed [CW-1:0] s1_sx_q, s1_sy_q, s1_v1x_q, s1_v1y_q;
  logic signed [DW-1:0] s1_lx_q, s1_ly_q, s1_dx_q, s1_dy_q, s1_vdx_q, s1_vdy_q;
  logic                 s1_pos_q, s1_vel_q;
  logic signed [CW-1:0] s2_sx_q, s2_sy_q, s2_v1x_q, s2_v1y_q;
  logic signed [DW-1:0] s2_lx_q, s2_ly_q, s2_dx_q, s2_dy_q, s2_vdx_q, s2_vdy_q;
  logic                 s2_pos_q, s2_vel_q;
  logic signed [2*DW-1:0] s2_lxlx_q, s2_lyly_q, s2_lxdx_q, s2_lydy_q;
  logic signed [2*DW:0]   len2_w, dot_w, dot_abs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_sx_q  <= raw_i.sx;
      s1_sy_q  <= raw_i.sy;
      s1_v1x_q <= raw_i.v1x;
      s1_v1y_q <= raw_i.v1y;
      s1_lx_q  <= DW'(raw_i.ex) - DW'(raw_i.sx);
      s1_ly_q  <= DW'(raw_i.ey) - DW'(raw_i.sy);
      s1_dx_q  <= DW'(raw_i.px) - DW'(raw_i.sx);
      s1_dy_q  <= DW'(raw_i.py) - DW'(raw_i.sy);
      s1_vdx_q <= DW'(raw_i.v2x) - DW'(raw_i.v1x);
      s1_vdy_q <= DW'(raw_i.v2y) - DW'(raw_i.v1y);
      s1_pos_q <= raw_i.pos_ok;
      s1_vel_q <= raw_i.vel_ok;

      s2_sx_q   <= s1_sx_q;
      s2_sy_q   <= s1_sy_q;
      s2_v1x_q  <= s1_v1x_q;
      s2_v1y_q  <= s1_v1y_q;
      s2_lx_q   <= s1_lx_q;
      s2_ly_q   <= s1_ly_q;
      s2_dx_q   <= s1_dx_q;
      s2_dy_q   <= s1_dy_q;
      s2_vdx_q  <= s1_vdx_q;
      s2_vdy_q  <= s1_vdy_q;
      s2_pos_q  <= s1_pos_q;
      s2_vel_q  <= s1_vel_q;
      s2_lxlx_q <= s1_lx_q * s1_lx_q;
      s2_lyly_q <= s1_ly_q * s1_ly_q;
      s2_lxdx_q <= s1_lx_q * s1_dx_q;
      s2_lydy_q <= s1_ly_q * s1_dy_q;
    end
  end

  always_comb begin
    len2_w  = (2*DW+1)'(s2_lxlx_q) + (2*DW+1)'(s2_lyly_q);
    dot_w   = (2*DW+1)'(s2_lxdx_q) + (2*DW+1)'(s2_lydy_q);
    dot_abs = dot_w[2*DW] ? -dot_w : dot_w;

    item_o.sx      = s2_sx_q;
    item_o.sy      = s2_sy_q;
    item_o.obx     = -s2_dx_q;
    item_o.oby     = -s2_dy_q;
    item_o.lx      = s2_lx_q;
    item_o.ly      = s2_ly_q;
    item_o.v1x     = s2_v1x_q;
    item_o.v1y     = s2_v1y_q;
    item_o.vdx     = s2_vdx_q;
    item_o.vdy     = s2_vdy_q;
    item_o.pos_ok  = s2_pos_q;
    item_o.vel_ok  = s2_vel_q;
    item_o.dot_neg = dot_w[2*DW];
    item_o.dot_mag = dot_abs[MAG_W-1:0];
    item_o.len2    = len2_w[MAG_W-1:0];
  end

  assign push_o = s2_v_q & adv_i;

endmodule
`default_nettype wire

// File: design/lscp_fifo.sv
// ----------------------------------------------------------------------------
// lscp_fifo
// Short queue between front and back; drains one word whenever not empty.
// ----------------------------------------------------------------------------
`default_nettype none
module lscp_fifo import lscp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       out_valid_o,
  output item_t      item_o
);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             pop;

  assign full_o      = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
  assign pop         = (cnt_q != '0);
  assign out_valid_o = pop;
  assign item_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PTR_W'(1);
      if (pop)    rd_q <= rd_q + PTR_W'(1);
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

// File: design/lscp_back.sv
// ----------------------------------------------------------------------------
// lscp_back
// Pipelined root, three pipelined dividers, clamp and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_segment_closest_point_assert.svh"
module lscp_back import lscp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire item_t            in_item_i,
  input  wire logic [CUT_W-1:0] start_cut_i,
  input  wire logic [CUT_W-1:0] end_cut_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam int BACK_LAT = SQ_STEPS + QW + 5;

  typedef struct packed {
    item_t             it;
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    item_t             it;
    logic [ROOT_W-1:0] len;
    logic [LD_W-1:0]   rl;
    logic [CD_W-1:0]   rs, re;
    logic [QW-1:0]     ql, qs, qe;
  } dv_t;

  typedef struct packed {
    item_t                  it;
    logic signed [LAM_W-1:0] lam;
    logic signed [LAM_W:0]   sumc;
  } cl_t;

  typedef struct packed {
    logic                  pos_ok, vel_ok;
    logic signed [DW-1:0]  obx, oby;
    logic signed [CW-1:0]  sx, sy, v1x, v1y;
    logic signed [PO_W-1:0] pox, poy, pvx, pvy;
    logic signed [PC_W-1:0] pcx, pcy;
  } mu_t;

  sq_t              sq_q [SQ_STEPS+1];
  logic [SQ_STEPS:0] sq_v_q;
  dv_t              dv_q [QW+1];
  logic [QW:0]      dv_v_q;
  cl_t              cl_q, cl_d;
  mu_t              mu_q;
  logic             cl_v_q, mu_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q      <= '0;
      dv_v_q      <= '0;
      cl_v_q      <= 1'b0;
      mu_v_q      <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      sq_v_q      <= {sq_v_q[SQ_STEPS-1:0], in_valid_i};
      dv_v_q      <= {dv_v_q[QW-1:0], sq_v_q[SQ_STEPS]};
      cl_v_q      <= dv_v_q[QW];
      mu_v_q      <= cl_v_q;
      res_valid_o <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0].it   <= in_item_i;
    sq_q[0].rem  <= SQ_W'(in_item_i.len2);
    sq_q[0].root <= '0;
  end

  // one root bit per stage, remainder kept as v - root^2
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam int B = SQ_STEPS - 1 - k;
    logic [SQ_W-1:0] trial;
    sq_t             nxt;
    always_comb begin
      trial = (SQ_W'(sq_q[k].root) << (B + 1)) | (SQ_W'(1) << (2 * B));
      nxt   = sq_q[k];
      if (sq_q[k].rem >= trial) begin
        nxt.rem  = sq_q[k].rem - trial;
        nxt.root = sq_q[k].root | (ROOT_W'(1) << B);
      end
    end
    always_ff @(posedge clk_i) sq_q[k+1] <= nxt;
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].it  <= sq_q[SQ_STEPS].it;
    dv_q[0].len <= sq_q[SQ_STEPS].root;
    dv_q[0].rl  <= LD_W'(sq_q[SQ_STEPS].it.dot_mag) << LAM_FB;
    dv_q[0].rs  <= CD_W'(start_cut_i) << LAM_FB;
    dv_q[0].re  <= CD_W'(end_cut_i) << LAM_FB;
    dv_q[0].ql  <= '0;
    dv_q[0].qs  <= '0;
    dv_q[0].qe  <= '0;
  end

  // restoring division, top quotient bits flag overflow
  for (genvar j = 0; j < QW; j++) begin : g_dv
    localparam int I = QW - 1 - j;
    logic [LD_W-1:0] dl;
    logic [CD_W-1:0] dc;
    dv_t             nxt;
    always_comb begin
      dl  = LD_W'(dv_q[j].it.len2) << I;
      dc  = CD_W'(dv_q[j].len) << I;
      nxt = dv_q[j];
      if (dv_q[j].rl >= dl) begin
        nxt.rl    = dv_q[j].rl - dl;
        nxt.ql[I] = 1'b1;
      end
      if (dv_q[j].rs >= dc) begin
        nxt.rs    = dv_q[j].rs - dc;
        nxt.qs[I] = 1'b1;
      end
      if (dv_q[j].re >= dc) begin
        nxt.re    = dv_q[j].re - dc;
        nxt.qe[I] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) dv_q[j+1] <= nxt;
  end

  // saturate and clamp lambda; upper bound first so the lower bound wins
  logic                    geo_ok;
  logic signed [LAM_W-1:0] lam_raw, ls, le, lam_c, qmag;
  logic signed [LE_W-1:0]  le_ext;

  always_comb begin
    geo_ok = dv_q[QW].it.pos_ok && (dv_q[QW].it.len2 != '0);
    qmag   = $signed(dv_q[QW].ql[LAM_W-1:0]);
    if (|dv_q[QW].ql[QW-1:LAM_W-1]) begin
      lam_raw = dv_q[QW].it.dot_neg ? LAM_MIN : LAM_MAX;
    end else begin
      lam_raw = dv_q[QW].it.dot_neg ? -qmag : qmag;
    end
    ls = (|dv_q[QW].qs[QW-1:LAM_W-1]) ? LAM_MAX : $signed(dv_q[QW].qs[LAM_W-1:0]);
    le_ext = LE_ONE - $signed(LE_W'(dv_q[QW].qe));
    if (dv_q[QW].qe[QW-1] || (le_ext < LE_MIN)) begin
      le = LAM_MIN;
    end else begin
      le = le_ext[LAM_W-1:0];
    end
    lam_c = lam_raw;
    if (lam_c > le) lam_c = le;
    if (lam_c < ls) lam_c = ls;
    if (!geo_ok) begin
      lam_c = '0;
      ls    = '0;
      le    = '0;
    end
    cl_d.it   = dv_q[QW].it;
    cl_d.lam  = lam_c;
    cl_d.sumc = (LAM_W+1)'(ls) + (LAM_W+1)'(le);
  end

  always_ff @(posedge clk_i) begin
    cl_q <= cl_d;

    mu_q.pos_ok <= cl_q.it.pos_ok;
    mu_q.vel_ok <= cl_q.it.vel_ok;
    mu_q.obx    <= cl_q.it.obx;
    mu_q.oby    <= cl_q.it.oby;
    mu_q.sx     <= cl_q.it.sx;
    mu_q.sy     <= cl_q.it.sy;
    mu_q.v1x    <= cl_q.it.v1x;
    mu_q.v1y    <= cl_q.it.v1y;
    mu_q.pox    <= cl_q.lam * cl_q.it.lx;
    mu_q.poy    <= cl_q.lam * cl_q.it.ly;
    mu_q.pvx    <= cl_q.lam * cl_q.it.vdx;
    mu_q.pvy    <= cl_q.lam * cl_q.it.vdy;
    mu_q.pcx    <= cl_q.sumc * cl_q.it.lx;
    mu_q.pcy    <= cl_q.sumc * cl_q.it.ly;

    res_o.offset_valid <= mu_q.pos_ok;
    res_o.center_valid <= mu_q.pos_ok;
    res_o.vel_valid    <= mu_q.vel_ok;
    if (mu_q.pos_ok) begin
      res_o.offset_x <= lerp_sat(ACC_W'(mu_q.obx), ACC_W'(mu_q.pox), LAM_FB);
      res_o.offset_y <= lerp_sat(ACC_W'(mu_q.oby), ACC_W'(mu_q.poy), LAM_FB);
      res_o.center_x <= lerp_sat(ACC_W'(mu_q.sx), ACC_W'(mu_q.pcx), LAM_FB + 1);
      res_o.center_y <= lerp_sat(ACC_W'(mu_q.sy), ACC_W'(mu_q.pcy), LAM_FB + 1);
    end else begin
      res_o.offset_x <= '0;
      res_o.offset_y <= '0;
      res_o.center_x <= '0;
      res_o.center_y <= '0;
    end
    if (mu_q.vel_ok) begin
      res_o.vel_x <= lerp_sat(ACC_W'(mu_q.v1x), ACC_W'(mu_q.pvx), LAM_FB);
      res_o.vel_y <= lerp_sat(ACC_W'(mu_q.v1y), ACC_W'(mu_q.pvy), LAM_FB);
    end else begin
      res_o.vel_x <= '0;
      res_o.vel_y <= '0;
    end
  end

  logic res_pos_zero, res_vel_zero, cl_lam_zero;

  assign res_pos_zero = (res_o.offset_x == '0) && (res_o.offset_y == '0) &&
                        (res_o.center_x == '0) && (res_o.center_y == '0);
  assign res_vel_zero = (res_o.vel_x == '0) && (res_o.vel_y == '0);
  assign cl_lam_zero  = (cl_q.lam == '0) && (cl_q.sumc == '0);

  `LSCP_ASSERT(a_latency, clk_i, rst_ni, in_valid_i |-> ##BACK_LAT res_valid_o)
  `LSCP_ASSERT(a_pos_zero, clk_i, rst_ni, (res_valid_o && !res_o.offset_valid) |-> res_pos_zero)
  `LSCP_ASSERT(a_vel_zero, clk_i, rst_ni, (res_valid_o && !res_o.vel_valid) |-> res_vel_zero)
  `LSCP_ASSERT_NEXT(a_lam_zero, clk_i, rst_ni, dv_v_q[QW] && !dv_q[QW].it.pos_ok, cl_lam_zero)

endmodule
`default_nettype wire

// File: design/line_segment_closest_point.sv
// ----------------------------------------------------------------------------
// line_segment_closest_point
// Closest point on a trimmed segment, interpolated velocity, trimmed centre.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | direction
//  command   | start, busy, start_x_i .. velocities_valid_i | in
//  result    | out_valid_o, offset_x_o .. center_valid_o | out
//  config    | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb
//
// Takes one word per cycle while busy is low; each result strobes after
// passing the 35-stage root and the 33-stage divider pipeline.
// busy rises only when the inter-stage queue is full.
// Reset clears the cutoffs and all stage valid bits; no clearing pass.
// Results cannot be held off: each is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module line_segment_closest_point import lscp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] end_x_i,
  input  wire logic signed [31:0] end_y_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] start_vel_x_i,
  input  wire logic signed [31:0] start_vel_y_i,
  input  wire logic signed [31:0] end_vel_x_i,
  input  wire logic signed [31:0] end_vel_y_i,
  input  wire logic              positions_valid_i,
  input  wire logic              velocities_valid_i,
  output logic                   out_valid_o,
  output logic signed [31:0]     offset_x_o,
  output logic signed [31:0]     offset_y_o,
  output logic signed [31:0]     vel_x_o,
  output logic signed [31:0]     vel_y_o,
  output logic                   offset_valid_o,
  output logic                   vel_valid_o,
  output logic signed [31:0]     center_x_o,
  output logic signed [31:0]     center_y_o,
  output logic                   center_valid_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [CUT_W-1:0] start_cutoff_q, end_cutoff_q;
  logic             cfg_wr, fifo_full, push, bk_valid;
  raw_t             raw;
  item_t            fe_item, bk_item;
  res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? 32'(end_cutoff_q) : 32'(start_cutoff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cutoff_q <= '0;
      end_cutoff_q   <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) end_cutoff_q   <= pwdata[CUT_W-1:0];
      else          start_cutoff_q <= pwdata[CUT_W-1:0];
    end
  end

  assign busy = fifo_full;

  always_comb begin
    raw.sx     = start_x_i;
    raw.sy     = start_y_i;
    raw.ex     = end_x_i;
    raw.ey     = end_y_i;
    raw.px     = point_x_i;
    raw.py     = point_y_i;
    raw.v1x    = start_vel_x_i;
    raw.v1y    = start_vel_y_i;
    raw.v2x    = end_vel_x_i;
    raw.v2y    = end_vel_y_i;
    raw.pos_ok = positions_valid_i;
    raw.vel_ok = velocities_valid_i;
  end

  lscp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start & ~busy),
    .raw_i      (raw),
    .adv_i      (~fifo_full),
    .push_o     (push),
    .item_o     (fe_item)
  );

  lscp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (fe_item),
    .full_o      (fifo_full),
    .out_valid_o (bk_valid),
    .item_o      (bk_item)
  );

  lscp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_item_i   (bk_item),
    .start_cut_i (start_cutoff_q),
    .end_cut_i   (end_cutoff_q),
    .res_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign offset_x_o     = res.offset_x;
  assign offset_y_o     = res.offset_y;
  assign vel_x_o        = res.vel_x;
  assign vel_y_o        = res.vel_y;
  assign offset_valid_o = res.offset_valid;
  assign vel_valid_o    = res.vel_valid;
  assign center_x_o     = res.center_x;
  assign center_y_o     = res.center_y;
  assign center_valid_o = res.center_valid;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Closest point block testbench
// Drives query words through the command port and predicts each result:
// projection onto the trimmed segment, interpolated velocity and centre.
// The cutoff registers are set over APB between phases. Results are checked
// field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import lscp_pkg::*;

  typedef logic signed [127:0] swide_t;
  typedef logic [127:0]        uwide_t;

  localparam int     LAMBDA_FB  = 30;
  localparam swide_t LAMBDA_TOP = (swide_t'(1) <<< (LAMBDA_FB + 1)) - 1;
  localparam swide_t LAMBDA_BOT = -(swide_t'(1) <<< (LAMBDA_FB + 1));
  localparam swide_t COORD_TOP  = 128'sd2147483647;
  localparam swide_t COORD_BOT  = -128'sd2147483648;
  localparam logic [2:0] ADDR_START_CUT = 3'd0;
  localparam logic [2:0] ADDR_END_CUT   = 3'd4;
  localparam int     DRAIN_CYCLES = 100;
  localparam int     STALL_LIMIT  = 20000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  raw_t drv_word = '0;
  logic out_valid_o, offset_valid_o, vel_valid_o, center_valid_o;
  logic signed [31:0] offset_x_o, offset_y_o, vel_x_o, vel_y_o, center_x_o, center_y_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  raw_t word_q[$];
  res_t closest_q[$];
  logic [30:0] start_cut = '0, end_cut = '0;
  int idle_pct = 0;
  int err_cnt = 0, words_in = 0, results_out = 0, stall_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  line_segment_closest_point i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .start_x_i(drv_word.sx), .start_y_i(drv_word.sy),
    .end_x_i(drv_word.ex), .end_y_i(drv_word.ey),
    .point_x_i(drv_word.px), .point_y_i(drv_word.py),
    .start_vel_x_i(drv_word.v1x), .start_vel_y_i(drv_word.v1y),
    .end_vel_x_i(drv_word.v2x), .end_vel_y_i(drv_word.v2y),
    .positions_valid_i(drv_word.pos_ok), .velocities_valid_i(drv_word.vel_ok),
    .out_valid_o, .offset_x_o, .offset_y_o, .vel_x_o, .vel_y_o,
    .offset_valid_o, .vel_valid_o, .center_x_o, .center_y_o, .center_valid_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // (base << sh + lam * diff) >> sh, floor, clipped to 32 bits
  function automatic logic signed [31:0] interp(swide_t base, swide_t lam, swide_t diff,
                                                int sh);
    swide_t acc;
    acc = ((base <<< sh) + lam * diff) >>> sh;
    if (acc > COORD_TOP) return SMAX;
    if (acc < COORD_BOT) return SMIN;
    return acc[31:0];
  endfunction

  function automatic res_t predict_closest(raw_t w);
    swide_t sx, sy, px, py, lx, ly, len2, dot, lam, ls, le, qs, qe;
    uwide_t len, t;
    res_t r;
    r = '0;
    lam = 0; ls = 0; le = 0;
    sx = w.sx; sy = w.sy; px = w.px; py = w.py;
    lx = swide_t'(w.ex) - sx;
    ly = swide_t'(w.ey) - sy;
    len2 = lx * lx + ly * ly;
    if (w.pos_ok) begin
      if (len2 != 0) begin
        len = '0;
        for (int b = 34; b >= 0; b--) begin
          t = len | (uwide_t'(1) << b);
          if (t * t <= uwide_t'(len2)) len = t;
        end
        qs = swide_t'((uwide_t'(start_cut) << LAMBDA_FB) / len);
        qe = swide_t'((uwide_t'(end_cut) << LAMBDA_FB) / len);
        dot = lx * (px - sx) + ly * (py - sy);
        lam = (dot <<< LAMBDA_FB) / len2;
        if (lam > LAMBDA_TOP) lam = LAMBDA_TOP;
        else if (lam < LAMBDA_BOT) lam = LAMBDA_BOT;
        ls = (qs > LAMBDA_TOP) ? LAMBDA_TOP : qs;
        le = (swide_t'(1) <<< LAMBDA_FB) - qe;
        if (le < LAMBDA_BOT) le = LAMBDA_BOT;
        // upper bound first so the start trim wins when they cross
        if (lam > le) lam = le;
        if (lam < ls) lam = ls;
      end
      r.offset_x = interp(sx - px, lam, lx, LAMBDA_FB);
      r.offset_y = interp(sy - py, lam, ly, LAMBDA_FB);
      r.center_x = interp(sx, ls + le, lx, LAMBDA_FB + 1);
      r.center_y = interp(sy, ls + le, ly, LAMBDA_FB + 1);
    end
    if (w.vel_ok) begin
      r.vel_x = interp(w.v1x, lam, swide_t'(w.v2x) - swide_t'(w.v1x), LAMBDA_FB);
      r.vel_y = interp(w.v1y, lam, swide_t'(w.v2y) - swide_t'(w.v1y), LAMBDA_FB);
    end
    r.offset_valid = w.pos_ok;
    r.vel_valid    = w.vel_ok;
    r.center_valid = w.pos_ok;
    return r;
  endfunction

  // driver: hold the word while busy, advance on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        closest_q.push_back(predict_closest(drv_word));
        words_in++;
      end
      if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        drv_word <= word_q.pop_front();
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("MISMATCH %s: expected %0d (%h), got %0d (%h)", name, exp_v, exp_v,
                 act_v, act_v);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o) begin
      results_out++;
      if (closest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("MISMATCH: result with no word outstanding");
      end else begin
        e = closest_q.pop_front();
        check_field("offset_x", e.offset_x, offset_x_o);
        check_field("offset_y", e.offset_y, offset_y_o);
        check_field("vel_x", e.vel_x, vel_x_o);
        check_field("vel_y", e.vel_y, vel_y_o);
        check_field("offset_valid", 32'(e.offset_valid), 32'(offset_valid_o));
        check_field("vel_valid", 32'(e.vel_valid), 32'(vel_valid_o));
        check_field("center_x", e.center_x, center_x_o);
        check_field("center_y", e.center_y, center_y_o);
        check_field("center_valid", 32'(e.center_valid), 32'(center_valid_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_START_CUT) start_cut = data[30:0];
    else end_cut = data[30:0];
  endtask

  task automatic apb_check(logic [2:0] addr, logic [30:0] want);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    check_field("register readback", {1'b0, want}, prdata);
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // wait until every word is out and the pipeline has drained
  task automatic drain();
    wait (word_q.size() == 0 && !start && closest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_cutoffs(logic [31:0] s, logic [31:0] e);
    drain();
    apb_write(ADDR_START_CUT, s);
    apb_write(ADDR_END_CUT, e);
    apb_check(ADDR_START_CUT, start_cut);
    apb_check(ADDR_END_CUT, end_cut);
  endtask

  function automatic raw_t mk(int sx, int sy, int ex, int ey, int px, int py,
                              int v1x, int v1y, int v2x, int v2y, bit pv, bit vv);
    raw_t w;
    w.sx = sx; w.sy = sy; w.ex = ex; w.ey = ey; w.px = px; w.py = py;
    w.v1x = v1x; w.v1y = v1y; w.v2x = v2x; w.v2y = v2y;
    w.pos_ok = pv; w.vel_ok = vv;
    return w;
  endfunction

  function automatic logic signed [31:0] rnd_coord(int kind);
    case (kind)
      0: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      1: return $urandom;
      default: begin
        case ($urandom_range(4))
          0: return SMAX;
          1: return SMIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic raw_t rand_word();
    raw_t w;
    int sel, kind;
    sel = $urandom_range(99);
    kind = (sel < 70) ? 0 : (sel < 85) ? 1 : 2;
    w.sx = rnd_coord(kind); w.sy = rnd_coord(kind);
    w.ex = rnd_coord(kind); w.ey = rnd_coord(kind);
    w.px = rnd_coord(kind); w.py = rnd_coord(kind);
    w.v1x = rnd_coord(kind); w.v1y = rnd_coord(kind);
    w.v2x = rnd_coord(kind); w.v2y = rnd_coord(kind);
    // zero-length and axis-aligned segments
    if ($urandom_range(19) == 0) begin
      w.ex = w.sx; w.ey = w.sy;
    end else if ($urandom_range(19) == 0) begin
      w.ey = w.sy;
    end
    w.pos_ok = ($urandom_range(9) != 0);
    w.vel_ok = ($urandom_range(9) != 0);
    return w;
  endfunction

  task automatic random_words(int n);
    repeat (n) word_q.push_back(rand_word());
  endtask

  localparam int Q = 65536;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cutoffs at reset value
    idle_pct = 0;
    word_q.push_back(mk(0, 0, 0, 0, 0, 0, Q, -Q, 2*Q, Q, 1, 1));
    word_q.push_back(mk(0, 0, 10*Q, 0, 5*Q, 3*Q, 0, 0, 4*Q, -2*Q, 1, 1));
    word_q.push_back(mk(0, 0, 10*Q, 0, 20*Q, -Q, Q, Q, 3*Q, 3*Q, 1, 1));
    word_q.push_back(mk(0, 0, 10*Q, 0, -5*Q, Q, Q, Q, 3*Q, 3*Q, 1, 1));
    word_q.push_back(mk(Q, Q, 4*Q, 5*Q, 2*Q, 2*Q, Q, Q, 2*Q, 2*Q, 0, 1));
    word_q.push_back(mk(Q, Q, 4*Q, 5*Q, 2*Q, 2*Q, Q, Q, 2*Q, 2*Q, 1, 0));
    word_q.push_back(mk(SMIN, SMIN, SMAX, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, 1, 1));
    word_q.push_back(mk(SMAX, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN, SMAX, 1, 1));
    word_q.push_back(mk(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1, 1));
    word_q.push_back(mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 1, 1));
    word_q.push_back(mk(0, SMIN, 0, SMAX, SMAX, 0, 0, SMAX, 0, SMIN, 1, 1));
    word_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0));
    random_words(250);

    set_cutoffs(3*Q, 4*Q);
    idle_pct = 73;
    word_q.push_back(mk(0, 0, 10*Q, 0, 5*Q, Q, 0, 0, 10*Q, 0, 1, 1));
    word_q.push_back(mk(0, 0, 10*Q, 0, Q, Q, 0, 0, 10*Q, 0, 1, 1));
    word_q.push_back(mk(0, 0, 10*Q, 0, 9*Q, Q, 0, 0, 10*Q, 0, 1, 1));
    random_words(270);

    // cutoffs cross on any short segment
    set_cutoffs(32'hffff_ffff, 32'h7fff_ffff);
    idle_pct = 21;
    word_q.push_back(mk(0, 0, 10*Q, 0, 5*Q, Q, 0, 0, 10*Q, 0, 1, 1));
    word_q.push_back(mk(SMIN, 0, SMAX, 0, 0, 0, 0, 0, Q, Q, 1, 1));
    random_words(270);

    set_cutoffs(32'h0000_0001, 32'h8000_0000);
    idle_pct = 0;
    random_words(270);

    set_cutoffs($urandom_range(0, 20*Q), $urandom_range(0, 20*Q));
    idle_pct = 50;
    random_words(150);
    // hold the sender until everything is out, then resume
    drain();
    idle_pct = 0;
    random_words(120);

    set_cutoffs($urandom, $urandom);
    idle_pct = 73;
    random_words(150);
    wait (word_q.size() == 0);
    idle_pct = 0;
    random_words(150);

    drain();
    $display("Sent %0d query words over six cutoff settings and four idle rates;",
             words_in);
    $display("checked %0d results and the cutoff registers after each write.",
             results_out);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
